@@ src/bcc_pkg.sv @@
// Shared types, opcode constants and decode helpers for the byte-coded core.
// Used by the controller, the datapath and the top level; depends on nothing.
package bcc_pkg;

    // Sizes of the architectural stores.
    localparam int BCC_REG_COUNT   = 256;
    localparam int BCC_INSTR_BYTES = 256;
    localparam int BCC_DATA_BYTES  = 4096;

    // A step at or beyond this counter value halts instead of fetching.
    localparam logic [7:0] FETCH_LIMIT = 8'd252;

    // Request kinds.
    localparam logic [1:0] KIND_STEP  = 2'd0;
    localparam logic [1:0] KIND_LOADI = 2'd1;
    localparam logic [1:0] KIND_LOADD = 2'd2;

    // Opcodes.
    localparam logic [7:0] OP_HALT     = 8'h00;
    localparam logic [7:0] OP_ADD      = 8'h01;
    localparam logic [7:0] OP_SUB      = 8'h02;
    localparam logic [7:0] OP_MUL      = 8'h03;
    localparam logic [7:0] OP_DIV      = 8'h04;
    localparam logic [7:0] OP_LD       = 8'h05;
    localparam logic [7:0] OP_ST       = 8'h06;
    localparam logic [7:0] OP_MOV      = 8'h07;
    localparam logic [7:0] OP_ADDI     = 8'h09;
    localparam logic [7:0] OP_SUBI     = 8'h0A;
    localparam logic [7:0] OP_MULI     = 8'h0B;
    localparam logic [7:0] OP_DIVI     = 8'h0C;
    localparam logic [7:0] OP_LDI      = 8'h0D;
    localparam logic [7:0] OP_STI      = 8'h0E;
    localparam logic [7:0] OP_MOVI     = 8'h0F;
    localparam logic [7:0] OP_BR_FIRST = 8'h10;
    localparam logic [7:0] OP_BR_LAST  = 8'h1E;

    // Branch condition codes.
    localparam logic [3:0] CC_EQ = 4'h0;
    localparam logic [3:0] CC_NE = 4'h1;
    localparam logic [3:0] CC_CS = 4'h2;
    localparam logic [3:0] CC_CC = 4'h3;
    localparam logic [3:0] CC_MI = 4'h4;
    localparam logic [3:0] CC_PL = 4'h5;
    localparam logic [3:0] CC_VS = 4'h6;
    localparam logic [3:0] CC_VC = 4'h7;
    localparam logic [3:0] CC_HI = 4'h8;
    localparam logic [3:0] CC_LS = 4'h9;
    localparam logic [3:0] CC_GE = 4'hA;
    localparam logic [3:0] CC_LT = 4'hB;
    localparam logic [3:0] CC_GT = 4'hC;
    localparam logic [3:0] CC_LE = 4'hD;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] load_addr;
        logic [7:0]  load_byte;
    } t_req;

    typedef struct packed {
        logic               halted;
        logic [7:0]         pc;
        logic               reg_written;
        logic [7:0]         reg_index;
        logic signed [31:0] reg_value;
        logic               flag_n;
        logic               flag_z;
        logic               flag_c;
        logic               flag_v;
    } t_rsp;

    // Instruction classes as the controller sees them.
    typedef enum logic [2:0] {
        OC_HALT, OC_ALU, OC_DIV, OC_LOAD, OC_STORE, OC_BRANCH, OC_NOP
    } t_opclass;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_DEC, S_RD, S_EX, S_DIV, S_DFIN, S_MEM, S_LTAIL, S_WB, S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       fetch_rd;
        logic       ins_shift;
        logic       pc_adv;
        logic       rf_rd;
        logic       ex;
        logic       div_step;
        logic       div_fin;
        logic       mem_rd;
        logic       mem_wr;
        logic       ld_shift;
        logic       wb;
        logic       set_halt;
        logic [1:0] cnt;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic     halted;
        logic     pc_end;
        logic     addr_ok;
        t_opclass opc;
    } t_sts;

    function automatic t_opclass decode_op(input logic [7:0] op);
        t_opclass c;
        c = OC_NOP;
        if (op == OP_HALT) begin
            c = OC_HALT;
        end else if (op inside {OP_ADD, OP_SUB, OP_MUL, OP_MOV,
                                OP_ADDI, OP_SUBI, OP_MULI, OP_MOVI}) begin
            c = OC_ALU;
        end else if (op inside {OP_DIV, OP_DIVI}) begin
            c = OC_DIV;
        end else if (op inside {OP_LD, OP_LDI}) begin
            c = OC_LOAD;
        end else if (op inside {OP_ST, OP_STI}) begin
            c = OC_STORE;
        end else if (op inside {[OP_BR_FIRST:OP_BR_LAST]}) begin
            c = OC_BRANCH;
        end
        return c;
    endfunction

    // Flags are packed as {n, z, c, v}.
    function automatic logic cond_met(input logic [3:0] cc, input logic [3:0] f);
        logic n, z, c, v, r;
        n = f[3];
        z = f[2];
        c = f[1];
        v = f[0];
        case (cc)
            CC_EQ:   r = z;
            CC_NE:   r = !z;
            CC_CS:   r = c;
            CC_CC:   r = !c;
            CC_MI:   r = n;
            CC_PL:   r = !n;
            CC_VS:   r = v;
            CC_VC:   r = !v;
            CC_HI:   r = c && !z;
            CC_LS:   r = !c || z;
            CC_GE:   r = n == v;
            CC_LT:   r = n != v;
            CC_GT:   r = !z && (n == v);
            CC_LE:   r = z || (n != v);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

@@ src/bcc_ctrl.sv @@
// Sequencing state machine of the byte-coded core.
// Depends on bcc_pkg; drives the datapath through the command struct.
module bcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_kind,
    input  bcc_pkg::t_sts i_sts,
    output bcc_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import bcc_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       w_acc;

    assign w_acc = i_start && (r_state == S_IDLE);

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 5'd1;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    if (i_kind == KIND_STEP && !i_sts.halted && !i_sts.pc_end) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: begin
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: n_state = S_RD;
            S_RD: begin
                if (i_sts.opc == OC_HALT || i_sts.opc == OC_NOP) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EX;
                end
            end
            S_EX: begin
                n_cnt = '0;
                case (i_sts.opc)
                    OC_ALU:   n_state = S_WB;
                    OC_DIV:   n_state = S_DIV;
                    OC_LOAD,
                    OC_STORE: n_state = i_sts.addr_ok ? S_MEM : S_DONE;
                    default:  n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: n_state = S_WB;
            S_MEM: begin
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = (i_sts.opc == OC_LOAD) ? S_LTAIL : S_DONE;
                end
            end
            S_LTAIL: n_state = S_WB;
            S_WB:    n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.cnt       = r_cnt[1:0];
        o_cmd.accept    = w_acc;
        o_cmd.fetch_rd  = (r_state == S_FETCH);
        o_cmd.ins_shift = ((r_state == S_FETCH) && (r_cnt[1:0] != 2'd0))
                          || (r_state == S_DEC);
        o_cmd.pc_adv    = (r_state == S_DEC);
        o_cmd.rf_rd     = (r_state == S_RD);
        o_cmd.ex        = (r_state == S_EX);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.div_fin   = (r_state == S_DFIN);
        o_cmd.mem_rd    = (r_state == S_MEM) && (i_sts.opc == OC_LOAD);
        o_cmd.mem_wr    = (r_state == S_MEM) && (i_sts.opc == OC_STORE);
        o_cmd.ld_shift  = ((r_state == S_MEM) && (i_sts.opc == OC_LOAD)
                           && (r_cnt[1:0] != 2'd0)) || (r_state == S_LTAIL);
        o_cmd.wb        = (r_state == S_WB);
        o_cmd.set_halt  = (w_acc && i_kind == KIND_STEP && !i_sts.halted && i_sts.pc_end)
                          || ((r_state == S_RD) && (i_sts.opc == OC_HALT));
        o_busy          = (r_state != S_IDLE);
        o_done          = (r_state == S_DONE);
    end

endmodule

@@ src/bcc_dpath.sv @@
// Datapath of the byte-coded core: stores, register file, ALU and divider.
// Depends on bcc_pkg; sequenced by bcc_ctrl through the command struct.
module bcc_dpath #(
    parameter int DATA_BYTES = bcc_pkg::BCC_DATA_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bcc_pkg::t_req i_req,
    input  bcc_pkg::t_cmd i_cmd,
    output bcc_pkg::t_sts o_sts,
    output bcc_pkg::t_rsp o_rsp
);
    import bcc_pkg::*;

    localparam int AW = $clog2(DATA_BYTES);

    // Stores.
    logic [7:0]  r_imem [BCC_INSTR_BYTES];
    logic [7:0]  r_dmem [DATA_BYTES];
    logic [31:0] r_rf   [BCC_REG_COUNT];
    logic [BCC_REG_COUNT-1:0] r_rfv;

    // Architectural state.
    logic [7:0]  r_pc;
    logic [3:0]  r_flags;
    logic        r_halt;

    // Working registers.
    logic [7:0]  r_ird;
    logic [31:0] r_instr;
    logic [31:0] r_rfa, r_rfb;
    logic        r_rfa_v, r_rfb_v;
    logic [31:0] r_res;
    logic [AW-1:0] r_addr;
    logic [31:0] r_sv;
    logic [7:0]  r_drd;
    logic [31:0] r_q, r_rem, r_dv;
    logic        r_neg, r_bz;
    logic        r_wr;
    logic [7:0]  r_idx;
    logic [31:0] r_val;

    logic [7:0]  w_op, w_d, w_s1, w_s2;
    logic        w_imm;
    logic [31:0] w_a, w_bv, w_b;
    logic [32:0] w_sum, w_dif;
    logic [31:0] w_prod;
    logic [31:0] w_ad;
    logic        w_aok;
    logic [7:0]  w_pc0;
    logic [10:0] w_off, w_tgt;
    logic [32:0] w_rsh, w_rdf;
    logic [31:0] w_dsum;
    logic        w_ldi, w_ldd;

    assign w_op  = r_instr[7:0];
    assign w_d   = r_instr[15:8];
    assign w_s1  = r_instr[23:16];
    assign w_s2  = r_instr[31:24];
    assign w_imm = w_op inside {[OP_ADDI:OP_MOVI]};
    assign w_a   = r_rfa_v ? r_rfa : 32'd0;
    assign w_bv  = r_rfb_v ? r_rfb : 32'd0;
    assign w_b   = w_imm ? {24'd0, w_s2} : w_bv;
    assign w_sum = {1'b0, w_a} + {1'b0, w_b};
    assign w_dif = {1'b0, w_a} - {1'b0, w_b};
    assign w_prod = w_a * w_b;

    assign w_ldi = i_cmd.accept && (i_req.kind == KIND_LOADI);
    assign w_ldd = i_cmd.accept && (i_req.kind == KIND_LOADD)
                   && (32'(i_req.load_addr) < 32'(DATA_BYTES));

    // Word address of a load or store; registers are read as signed.
    always_comb begin
        w_ad = {24'd0, w_s2};
        if (w_op == OP_LD) begin
            w_ad = w_bv;
        end else if (w_op == OP_ST) begin
            w_ad = w_a;
        end else if (w_op == OP_STI) begin
            w_ad = {24'd0, w_d};
        end
        w_aok = !w_ad[31] && (w_ad <= 32'(DATA_BYTES - 4));
    end

    // Branch target relative to the address of the branch.
    assign w_pc0 = r_pc - 8'd4;
    assign w_off = {{3{w_s2[7]}}, w_s2};
    assign w_tgt = {3'd0, w_pc0} + {w_off[8:0], 2'b00};

    // One restoring divide step on magnitudes.
    assign w_rsh = {1'b0, r_rem[30:0], r_q[31]};
    assign w_rdf = w_rsh - {1'b0, r_dv};
    assign w_dsum = r_neg ? (32'd0 - r_q) : r_q;

    // Instruction store and fetch read.
    always_ff @(posedge i_clk) begin
        if (w_ldi) begin
            r_imem[i_req.load_addr[7:0]] <= i_req.load_byte;
        end
        if (i_cmd.fetch_rd) begin
            r_ird <= r_imem[r_pc + {6'd0, i_cmd.cnt}];
        end
        if (i_cmd.ins_shift) begin
            r_instr <= {r_ird, r_instr[31:8]};
        end
    end

    // Data store: loader and store writes share one port.
    always_ff @(posedge i_clk) begin
        if (w_ldd) begin
            r_dmem[AW'(i_req.load_addr)] <= i_req.load_byte;
        end else if (i_cmd.mem_wr) begin
            r_dmem[r_addr + AW'(i_cmd.cnt)] <= r_sv[8*i_cmd.cnt +: 8];
        end
        if (i_cmd.mem_rd) begin
            r_drd <= r_dmem[r_addr + AW'(i_cmd.cnt)];
        end
    end

    // Register file array with two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_rf[w_d] <= r_res;
        end
        if (i_cmd.rf_rd) begin
            r_rfa   <= r_rf[(decode_op(w_op) == OC_STORE) ? w_d : w_s1];
            r_rfb   <= r_rf[w_s2];
        end
    end

    // Register valid bits; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rfv   <= '0;
            r_rfa_v <= 1'b0;
            r_rfb_v <= 1'b0;
        end else begin
            if (i_cmd.wb) begin
                r_rfv[w_d] <= 1'b1;
            end
            if (i_cmd.rf_rd) begin
                r_rfa_v <= r_rfv[(decode_op(w_op) == OC_STORE) ? w_d : w_s1];
                r_rfb_v <= r_rfv[w_s2];
            end
        end
    end

    // Execute, divide and load assembly.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ex) begin
            r_addr <= w_ad[AW-1:0];
            r_sv   <= w_bv;
            r_neg  <= w_a[31] ^ w_b[31];
            r_bz   <= (w_b == 32'd0);
            r_q    <= w_a[31] ? (32'd0 - w_a) : w_a;
            r_dv   <= w_b[31] ? (32'd0 - w_b) : w_b;
            r_rem  <= '0;
            if (w_op == OP_ADD || w_op == OP_ADDI) begin
                r_res <= w_sum[31:0];
            end else if (w_op == OP_SUB || w_op == OP_SUBI) begin
                r_res <= w_dif[31:0];
            end else if (w_op == OP_MUL || w_op == OP_MULI) begin
                r_res <= w_prod;
            end else begin
                r_res <= w_b;
            end
        end else if (i_cmd.div_step) begin
            if (!w_rdf[32]) begin
                r_rem <= w_rdf[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_rsh[31:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end else if (i_cmd.div_fin) begin
            r_res <= r_bz ? 32'd0 : w_dsum;
        end else if (i_cmd.ld_shift) begin
            r_res <= {r_drd, r_res[31:8]};
        end
    end

    // Program counter, flags, halt mark and the reported write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_flags <= '0;
            r_halt  <= 1'b0;
            r_wr    <= 1'b0;
            r_idx   <= '0;
            r_val   <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_wr  <= 1'b0;
                r_idx <= '0;
                r_val <= '0;
            end
            if (i_cmd.set_halt) begin
                r_halt <= 1'b1;
            end
            if (i_cmd.pc_adv) begin
                r_pc <= r_pc + 8'd4;
            end
            if (i_cmd.wb) begin
                r_wr  <= 1'b1;
                r_idx <= w_d;
                r_val <= r_res;
            end
            if (i_cmd.ex) begin
                if (w_op == OP_ADD || w_op == OP_ADDI) begin
                    r_flags <= {w_sum[31], w_sum[31:0] == 32'd0, w_sum[32],
                                (w_a[31] ^ w_sum[31]) & (w_b[31] ^ w_sum[31])};
                end else if (w_op == OP_SUB || w_op == OP_SUBI) begin
                    r_flags <= {w_dif[31], w_dif[31:0] == 32'd0, !w_dif[32],
                                (w_a[31] ^ w_b[31]) & (w_a[31] ^ w_dif[31])};
                end
                if (decode_op(w_op) == OC_BRANCH && cond_met(4'(w_op - OP_BR_FIRST), r_flags)) begin
                    if (w_tgt[10] || w_tgt[9:8] != 2'd0) begin
                        r_halt <= 1'b1;
                    end else begin
                        r_pc <= w_tgt[7:0];
                    end
                end
            end
        end
    end

    always_comb begin
        o_sts.halted  = r_halt;
        o_sts.pc_end  = (r_pc >= FETCH_LIMIT);
        o_sts.addr_ok = w_aok;
        o_sts.opc     = decode_op(w_op);

        o_rsp.halted      = r_halt;
        o_rsp.pc          = r_pc;
        o_rsp.reg_written = r_wr;
        o_rsp.reg_index   = r_idx;
        o_rsp.reg_value   = r_val;
        o_rsp.flag_n      = r_flags[3];
        o_rsp.flag_z      = r_flags[2];
        o_rsp.flag_c      = r_flags[1];
        o_rsp.flag_v      = r_flags[0];
    end

endmodule

@@ src/byte_coded_cpu_fetch_execute_top.sv @@
// Top level of the byte-coded core: joins the controller and the datapath.
// Depends on bcc_pkg, bcc_ctrl and bcc_dpath.
//
//  channel   signals                 direction  handshake
//  request   start, i_req            in         taken when start high, busy low
//  result    o_done, o_rsp           out        one-cycle strobe, no stall
//
// A loader request, an unknown kind, or a step on a halted core or at the fetch
// limit gives its result in the cycle after acceptance. An executed step does
// fetch reads of its four bytes on the single instruction-store port, decode,
// register read, execute, write back and result; a halt or unknown opcode ends
// at register read, a branch or out-of-range load/store at execute. Stores swap
// write back for byte-wide data-store accesses; loads add them and a tail step,
// divides radix-2 divider steps and a finish step. Synchronous active-low reset
// clears registers, flags and register valid bits; the stores need no clearing.
module byte_coded_cpu_fetch_execute_top #(
    parameter int DATA_BYTES = bcc_pkg::BCC_DATA_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bcc_pkg::t_req i_req,
    output logic          o_done,
    output bcc_pkg::t_rsp o_rsp
);
    import bcc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_req.kind),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bcc_dpath #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTHESIS
    // Each result returns the controller to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("busy after result");

    // An accepted request always occupies the core.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    // Halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.halted |=> o_rsp.halted) else $error("halt cleared");

    // A result without a register write reports zero index and value.
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.reg_written) |-> (o_rsp.reg_index == 8'd0
        && o_rsp.reg_value == 32'sd0)) else $error("stale write report");
`endif

endmodule

@@ tb/byte_coded_cpu_fetch_execute_top_tb.sv @@
// Testbench for the byte-coded core: loads programs and data bytes, steps the core
// and checks every result against an in-bench predictor of the architecture.
// Depends on bcc_pkg and byte_coded_cpu_fetch_execute_top.
`timescale 1ns / 1ps

module byte_coded_cpu_fetch_execute_top_tb;
    import bcc_pkg::*;

    // Number of low data-store bytes preloaded before any program runs.
    localparam int DATA_FILL = 384;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_done;
    t_rsp  o_rsp;

    byte_coded_cpu_fetch_execute_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // Architectural copy of the core used for prediction.
    logic [31:0] arch_regs [BCC_REG_COUNT];
    logic [7:0]  arch_imem [BCC_INSTR_BYTES];
    logic [7:0]  arch_dmem [BCC_DATA_BYTES];
    logic [7:0]  arch_pc;
    logic [3:0]  arch_flags;
    logic        arch_halted;

    t_req  pending_reqs [$];
    t_rsp  expected_rsps [$];
    int    error_count;
    bit    stim_done;
    int    gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [3:0] nz_of(input logic [31:0] r);
        return {r[31], r == 32'd0, 2'b00};
    endfunction

    function automatic logic branch_taken(input logic [3:0] cc, input logic [3:0] f);
        logic n, z, c, v;
        n = f[3];
        z = f[2];
        c = f[1];
        v = f[0];
        case (cc)
            CC_EQ: return z;
            CC_NE: return !z;
            CC_CS: return c;
            CC_CC: return !c;
            CC_MI: return n;
            CC_PL: return !n;
            CC_VS: return v;
            CC_VC: return !v;
            CC_HI: return c && !z;
            CC_LS: return !c || z;
            CC_GE: return n == v;
            CC_LT: return n != v;
            CC_GT: return !z && (n == v);
            CC_LE: return z || (n != v);
            default: return 1'b1;
        endcase
    endfunction

    // Executes one instruction step on the architectural copy.
    task automatic execute_step(output logic wr, output logic [7:0] idx,
                                output logic [31:0] val);
        logic [7:0]  pc0, op, d, s1, s2;
        logic [31:0] a, b, r;
        logic [32:0] sum;
        longint      ad, tgt;
        bit          imm;
        wr = 1'b0;
        idx = 8'd0;
        val = 32'd0;
        pc0 = arch_pc;
        if (pc0 >= FETCH_LIMIT) begin
            arch_halted = 1'b1;
            return;
        end
        op = arch_imem[pc0];
        d  = arch_imem[pc0 + 8'd1];
        s1 = arch_imem[pc0 + 8'd2];
        s2 = arch_imem[pc0 + 8'd3];
        arch_pc = pc0 + 8'd4;
        if (op == OP_HALT) begin
            arch_halted = 1'b1;
            return;
        end
        imm = (op >= OP_ADDI) && (op <= OP_MOVI);
        a = arch_regs[s1];
        b = imm ? {24'd0, s2} : arch_regs[s2];
        case (op)
            OP_ADD, OP_ADDI: begin
                sum = {1'b0, a} + {1'b0, b};
                r = sum[31:0];
                arch_flags = nz_of(r) | {2'b00, sum[32], ((a ^ r) & (b ^ r)) >> 31 != 0};
            end
            OP_SUB, OP_SUBI: begin
                r = a - b;
                arch_flags = nz_of(r) | {2'b00, a >= b, ((a ^ b) & (a ^ r)) >> 31 != 0};
            end
            OP_MUL, OP_MULI: r = a * b;
            OP_DIV, OP_DIVI: begin
                if (b == 32'd0) r = 32'd0;
                else r = 32'(longint'($signed(a)) / longint'($signed(b)));
            end
            OP_LD, OP_LDI: begin
                ad = (op == OP_LD) ? longint'($signed(arch_regs[s2])) : longint'(s2);
                if (ad < 0 || ad > BCC_DATA_BYTES - 4) return;
                r = {arch_dmem[ad + 3], arch_dmem[ad + 2], arch_dmem[ad + 1], arch_dmem[ad]};
            end
            OP_ST, OP_STI: begin
                ad = (op == OP_ST) ? longint'($signed(arch_regs[d])) : longint'(d);
                if (ad >= 0 && ad <= BCC_DATA_BYTES - 4) begin
                    for (int k = 0; k < 4; k++) arch_dmem[ad + k] = arch_regs[s2][8*k +: 8];
                end
                return;
            end
            OP_MOV, OP_MOVI: r = b;
            default: begin
                if (op >= OP_BR_FIRST && op <= OP_BR_LAST) begin
                    if (branch_taken(4'(op - OP_BR_FIRST), arch_flags)) begin
                        tgt = longint'(pc0) + 4 * longint'($signed(s2));
                        if (tgt < 0 || tgt > 255) arch_halted = 1'b1;
                        else arch_pc = 8'(tgt);
                    end
                end
                return;
            end
        endcase
        arch_regs[d] = r;
        wr = 1'b1;
        idx = d;
        val = r;
    endtask

    // Computes the result of one accepted request.
    task automatic predict_request(input t_req rq);
        t_rsp        rs;
        logic        wr;
        logic [7:0]  idx;
        logic [31:0] val;
        wr = 1'b0;
        idx = 8'd0;
        val = 32'd0;
        if (rq.kind == KIND_LOADI) arch_imem[rq.load_addr[7:0]] = rq.load_byte;
        else if (rq.kind == KIND_LOADD) arch_dmem[rq.load_addr] = rq.load_byte;
        else if (rq.kind == KIND_STEP && !arch_halted) execute_step(wr, idx, val);
        rs.halted      = arch_halted;
        rs.pc          = arch_pc;
        rs.reg_written = wr;
        rs.reg_index   = idx;
        rs.reg_value   = val;
        {rs.flag_n, rs.flag_z, rs.flag_c, rs.flag_v} = arch_flags;
        expected_rsps.push_back(rs);
    endtask

    // Stimulus builders.
    task automatic push_req(input logic [1:0] k, input logic [11:0] ad, input logic [7:0] by);
        t_req rq;
        rq.kind = k;
        rq.load_addr = ad;
        rq.load_byte = by;
        pending_reqs.push_back(rq);
    endtask

    task automatic put_instr(input int at, input logic [7:0] op, input logic [7:0] d,
                             input logic [7:0] s1, input logic [7:0] s2);
        push_req(KIND_LOADI, 12'(at), op);
        push_req(KIND_LOADI, 12'(at + 1), d);
        push_req(KIND_LOADI, 12'(at + 2), s1);
        push_req(KIND_LOADI, 12'(at + 3), s2);
    endtask

    // The low part of the data store is filled first, and random loads use only
    // immediate addresses, so every load reads written bytes.
    // Each program fills the whole instruction store, so every fetch is defined.
    task automatic random_program(input bit directed);
        logic [7:0] op, s2;
        int         r;
        for (int at = 0; at < 256; at += 4) begin
            r = $urandom_range(99);
            if (r < 8)       op = OP_MOVI;
            else if (r < 40) op = 8'($urandom_range(OP_ADD, OP_MOVI));
            else if (r < 70) op = 8'($urandom_range(OP_BR_FIRST, OP_BR_LAST));
            else if (r < 72) op = OP_HALT;
            else if (r < 76) op = 8'($urandom_range(8'h1F, 8'hFF));
            else             op = 8'($urandom_range(OP_ADD, OP_MOVI));
            if (op == 8'h08) op = OP_MOVI;
            if (op == OP_LD) op = OP_LDI;
            s2 = 8'($urandom);
            if (op >= OP_BR_FIRST && op <= OP_BR_LAST && $urandom_range(3) != 0)
                s2 = 8'($urandom_range(1, 3));
            if (!directed)
                put_instr(at, op, 8'($urandom_range(15) == 0 ? $urandom : $urandom_range(7)),
                          8'($urandom_range(15) == 0 ? $urandom : $urandom_range(7)),
                          ($urandom_range(3) == 0 || op >= OP_ADDI) ? s2
                                                                   : 8'($urandom_range(7)));
        end
    endtask

    // In the directed program, registers take wide values built by multiplies and immediates.
    initial begin
        t_req rq;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        error_count = 0;
        stim_done = 1'b0;
        gap_left = 0;
        for (int k = 0; k < BCC_REG_COUNT; k++) arch_regs[k] = 32'd0;
        for (int k = 0; k < BCC_DATA_BYTES; k++) arch_dmem[k] = 8'd0;
        for (int k = 0; k < BCC_INSTR_BYTES; k++) arch_imem[k] = 8'd0;
        arch_pc = 8'd0;
        arch_flags = 4'd0;
        arch_halted = 1'b0;
        for (int k = 0; k < DATA_FILL; k++)
            push_req(KIND_LOADD, 12'(k), 8'($urandom));
        // Directed program: extremes, flags, divide special cases, memory bounds.
        put_instr(0,  OP_MOVI, 8'd1, 8'd0, 8'hFF);
        put_instr(4,  OP_MULI, 8'd2, 8'd1, 8'hFF);
        put_instr(8,  OP_MUL,  8'd3, 8'd2, 8'd2);
        put_instr(12, OP_SUBI, 8'd4, 8'd0, 8'd1);
        put_instr(16, OP_ADDI, 8'd5, 8'd4, 8'd1);
        put_instr(20, OP_MOVI, 8'd6, 8'd0, 8'd1);
        put_instr(24, OP_MULI, 8'd6, 8'd6, 8'h80);
        put_instr(28, OP_MUL,  8'd7, 8'd6, 8'd6);
        put_instr(32, OP_MUL,  8'd7, 8'd7, 8'd6);
        put_instr(36, OP_MUL,  8'd7, 8'd7, 8'd6);
        put_instr(40, OP_DIV,  8'd8, 8'd7, 8'd4);
        put_instr(44, OP_DIVI, 8'd9, 8'd7, 8'd0);
        put_instr(48, OP_SUB,  8'd10, 8'd7, 8'd1);
        put_instr(52, OP_ADD,  8'd11, 8'd7, 8'd7);
        put_instr(56, OP_STI,  8'd252, 8'd0, 8'd7);
        put_instr(60, OP_LDI,  8'd255, 8'd0, 8'd252);
        put_instr(64, OP_ST,   8'd4, 8'd0, 8'd7);
        put_instr(68, OP_LD,   8'd12, 8'd0, 8'd4);
        put_instr(72, OP_MOVI, 8'd13, 8'd0, 8'd7);
        put_instr(76, OP_MULI, 8'd13, 8'd13, 8'hFF);
        put_instr(80, OP_MULI, 8'd13, 8'd13, 8'h49);
        put_instr(84, OP_ST,   8'd13, 8'd0, 8'd2);
        put_instr(88, OP_LD,   8'd14, 8'd0, 8'd13);
        put_instr(92, 8'h08,   8'd0, 8'd0, 8'd0);
        put_instr(96, 8'h1E,   8'd0, 8'd0, 8'd2);
        put_instr(104, 8'h11,  8'd0, 8'd0, 8'hE0);
        for (int k = 0; k < 26; k++) push_req(KIND_STEP, 12'($urandom), 8'($urandom));
        push_req(2'd3, 12'hFFF, 8'hFF);
        // Random phases: each reloads a program and steps it; the core only halts
        // once, so after a halt the random part keeps loading and stepping harmlessly.
        for (int ph = 0; ph < 3; ph++) begin
            random_program(1'b0);
            repeat (120) push_req(KIND_STEP, 12'($urandom), 8'($urandom));
            repeat (20) begin
                rq.kind = 2'($urandom_range(3));
                rq.load_addr = 12'($urandom);
                rq.load_byte = 8'($urandom);
                if (rq.kind == KIND_STEP) rq.kind = 2'd3;
                pending_reqs.push_back(rq);
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: holds start high until the request is taken, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) predict_request(i_req);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
                case ($urandom_range(9))
                    0, 1, 2: gap_left <= $urandom_range(3);
                    3:       gap_left <= $urandom_range(40);
                    default: gap_left <= 0;
                endcase
            end else begin
                start <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // Monitor: each strobe is compared with the oldest expected result.
    always @(posedge i_clk) begin
        t_rsp ex;
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                ex = expected_rsps.pop_front();
                if (o_rsp.halted !== ex.halted) begin
                    $error("halted: expected %0d, got %0d", ex.halted, o_rsp.halted);
                    error_count++;
                end
                if (o_rsp.pc !== ex.pc) begin
                    $error("pc: expected %0d, got %0d", ex.pc, o_rsp.pc);
                    error_count++;
                end
                if (o_rsp.reg_written !== ex.reg_written) begin
                    $error("reg_written: expected %0d, got %0d", ex.reg_written,
                           o_rsp.reg_written);
                    error_count++;
                end
                if (o_rsp.reg_index !== ex.reg_index) begin
                    $error("reg_index: expected %0d, got %0d", ex.reg_index, o_rsp.reg_index);
                    error_count++;
                end
                if (o_rsp.reg_value !== ex.reg_value) begin
                    $error("reg_value: expected %0d, got %0d", ex.reg_value, o_rsp.reg_value);
                    error_count++;
                end
                if ({o_rsp.flag_n, o_rsp.flag_z, o_rsp.flag_c, o_rsp.flag_v} !==
                    {ex.flag_n, ex.flag_z, ex.flag_c, ex.flag_v}) begin
                    $error("flags nzcv: expected %b%b%b%b, got %b%b%b%b", ex.flag_n, ex.flag_z,
                           ex.flag_c, ex.flag_v, o_rsp.flag_n, o_rsp.flag_z, o_rsp.flag_c,
                           o_rsp.flag_v);
                    error_count++;
                end
            end
        end
    end

    // End of run: drain outstanding results, then allow the block to settle.
    initial begin
        wait (stim_done);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ byte_coded_cpu_fetch_execute_top.f @@
src/bcc_pkg.sv
src/bcc_ctrl.sv
src/bcc_dpath.sv
src/byte_coded_cpu_fetch_execute_top.sv
tb/byte_coded_cpu_fetch_execute_top_tb.sv
